// ===== hw/rtl/i2cms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Shared constants, codes and types of the transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int BufferDepth = 32;
  localparam int TxqSize     = BufferDepth + 1;
  localparam int TxPtrW      = $clog2(TxqSize);
  localparam int TxFillW     = $clog2(TxqSize + 1);
  localparam int TxMemIdxW   = $clog2(BufferDepth);
  localparam int RxPtrW      = $clog2(BufferDepth);
  localparam int RxFillW     = $clog2(BufferDepth + 1);
  localparam int RcvCntW     = 6;
  localparam int CountW      = 6;
  localparam int InDataW     = 24;
  localparam int OutDataW    = 32;

  localparam logic [RcvCntW-1:0] RcvCntMax = '1;
  localparam logic               RdBit     = 1'b1;
  localparam logic               WrBit     = 1'b0;

  localparam logic CfgSlaveAddr = 1'b0;
  localparam logic CfgRepStart  = 1'b1;

  typedef enum logic [1:0] {
    ReqWrite = 2'd0,
    ReqRead  = 2'd1,
    ReqEvent = 2'd2,
    ReqPop   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    EvStart     = 4'd0,
    EvRepStart  = 4'd1,
    EvAddrWAck  = 4'd2,
    EvAddrWNack = 4'd3,
    EvTxAck     = 4'd4,
    EvTxNack    = 4'd5,
    EvArbLost   = 4'd6,
    EvAddrRAck  = 4'd7,
    EvAddrRNack = 4'd8,
    EvRxAck     = 4'd9,
    EvRxNack    = 4'd10,
    EvIllegal   = 4'd11,
    EvNoInfo    = 4'd12
  } bus_event_e;

  typedef enum logic [2:0] {
    ActNone  = 3'd0,
    ActStart = 3'd1,
    ActTx    = 3'd2,
    ActAck   = 3'd3,
    ActNack  = 3'd4,
    ActStop  = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ModeReady    = 3'd0,
    ModeInit     = 3'd1,
    ModeRepStart = 3'd2,
    ModeTx       = 3'd3,
    ModeRx       = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ErrNone      = 3'd0,
    ErrBusy      = 3'd1,
    ErrAddrWNack = 3'd2,
    ErrAddrRNack = 3'd3,
    ErrDataNack  = 3'd4,
    ErrArbLost   = 3'd5,
    ErrIllegal   = 3'd6
  } err_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatBusy     = 2'd1,
    StatTooLarge = 2'd2
  } status_e;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } rxq_ctrl_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rdata;
  } rxq_stat_t;

endpackage

// ===== hw/rtl/i2cms_rxq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer receive queue
// Circular byte queue; push drops when full, pop on empty reads nothing.
// ----------------------------------------------------------------------------
module i2cms_rxq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cms_pkg::rxq_ctrl_t  ctrl_i,
  output i2cms_pkg::rxq_stat_t  stat_o
);
  import i2cms_pkg::*;

  logic [7:0]         mem_q [BufferDepth];
  logic [RxPtrW-1:0]  head_q, head_d;
  logic [RxFillW-1:0] fill_q, fill_d;
  logic [RxFillW:0]   wsum;
  logic [RxFillW:0]   wsum_wrap;
  logic [RxPtrW-1:0]  widx;
  logic               push_ok, pop_ok;

  assign push_ok   = ctrl_i.push && (fill_q < RxFillW'(BufferDepth));
  assign pop_ok    = ctrl_i.pop && (fill_q != '0);
  assign wsum      = (RxFillW+1)'(head_q) + (RxFillW+1)'(fill_q);
  assign wsum_wrap = (wsum >= (RxFillW+1)'(BufferDepth)) ?
                     wsum - (RxFillW+1)'(BufferDepth) : wsum;
  assign widx      = wsum_wrap[RxPtrW-1:0];

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (push_ok) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_ok) begin
      fill_d = fill_q - 1'b1;
      head_d = (head_q == RxPtrW'(BufferDepth - 1)) ? '0 : head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[widx] <= ctrl_i.wdata;
    end
  end

  assign stat_o.valid = (fill_q != '0);
  assign stat_o.rdata = mem_q[head_q];

endmodule

// ===== hw/rtl/i2c_master_transfer_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Queues write and read transfers and answers bus status events with the
// next bus action, tracking mode, error code and received bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel: tuser carries the request kind
//   (write byte, read request, bus event, pop), tlast marks the last write
//   byte, tdata the byte, read count and bus event. Every input item yields
//   exactly one result item on m_axis.
//   Configuration (slave address, repeated start) is written through the
//   cfg port while the block is idle.
//   The state is updated and the result registered at the edge that accepts
//   the item. Throughput is one item per cycle; the
//   output register frees s_axis_tready_o whenever the result is taken in
//   the same cycle.
//   When the receiver stalls, the result is held and the input stalls with
//   it. Reset returns the block to ready mode with empty queues, no error and
//   no pending result.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [6:0]                    cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // data_byte[7:0], read_count[13:8], bus_event[17:14], zero pad
  input  logic [i2cms_pkg::InDataW-1:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]                    s_axis_tuser_i,
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // bus_action[2:0], tx_byte[10:3], mode[13:11], error_code[16:14],
  // request_status[18:17], rx_byte[26:19], rx_valid[27], ready_res[28], pad
  output logic [i2cms_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import i2cms_pkg::*;

  // configuration
  logic [6:0] slave_addr_q;
  logic       rep_start_q;

  // sequencer state
  mode_e               mode_q, mode_d;
  err_e                err_q, err_d;
  logic [TxPtrW-1:0]   txq_head_q, txq_head_d;
  logic [TxFillW-1:0]  txq_fill_q, txq_fill_d;
  logic [7:0]          txq_slot0_q;
  logic [7:0]          txq_mem_q [BufferDepth];
  logic                loading_q, loading_d;
  logic [CountW-1:0]   rd_target_q, rd_target_d;
  logic [RcvCntW-1:0]  rcv_cnt_q, rcv_cnt_d;

  // output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // item decode
  logic                acc;
  req_e                req;
  bus_event_e          ev;
  logic [7:0]          data_byte;
  logic [CountW-1:0]   read_count;
  logic                is_last;

  // transmit queue write/read control
  logic                slot0_we;
  logic [7:0]          slot0_wval;
  logic                mem_we;
  logic [TxPtrW-1:0]   mem_widx;
  logic [TxMemIdxW-1:0] mem_wsel;
  logic [7:0]          mem_wval;
  logic                pop_en;
  logic [7:0]          pop_val;
  logic [TxPtrW:0]     wsum;
  logic [RcvCntW:0]    cnt_next;

  // result
  action_e             act;
  logic [7:0]          txb;
  status_e             status;
  logic                ready_now, ready_res;
  rxq_ctrl_t           rxq_ctrl;
  rxq_ctrl_t           rxq_req;
  rxq_stat_t           rxq_stat;
  logic [7:0]          rxb;
  logic                rxv;

  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign req             = req_e'(s_axis_tuser_i);
  assign data_byte       = s_axis_tdata_i[7:0];
  assign read_count      = s_axis_tdata_i[13:8];
  assign ev              = bus_event_e'(s_axis_tdata_i[17:14]);
  assign is_last         = s_axis_tlast_i;
  assign ready_now       = (mode_q == ModeReady) || (mode_q == ModeRepStart);

  always_comb begin
    mode_d      = mode_q;
    err_d       = err_q;
    txq_head_d  = txq_head_q;
    txq_fill_d  = txq_fill_q;
    loading_d   = loading_q;
    rd_target_d = rd_target_q;
    rcv_cnt_d   = rcv_cnt_q;
    slot0_we    = 1'b0;
    slot0_wval  = data_byte;
    mem_we      = 1'b0;
    mem_widx    = '0;
    mem_wval    = data_byte;
    pop_en      = 1'b0;
    pop_val     = '0;
    act         = ActNone;
    status      = StatOk;
    rxq_ctrl    = '{push: 1'b0, pop: 1'b0, wdata: data_byte};
    rxb         = '0;
    rxv         = 1'b0;
    wsum        = '0;
    cnt_next    = '0;

    case (req)
      ReqWrite: begin
        if (!ready_now) begin
          status = StatBusy;
        end else begin
          if (!loading_q) begin
            txq_head_d = '0;
            txq_fill_d = TxFillW'(1);
            slot0_we   = 1'b1;
            slot0_wval = {slave_addr_q, WrBit};
            loading_d  = 1'b1;
          end
          if (txq_fill_d >= TxFillW'(TxqSize)) begin
            status     = StatTooLarge;
            txq_head_d = '0;
            txq_fill_d = '0;
            loading_d  = 1'b0;
          end else begin
            wsum = (TxPtrW+1)'(txq_head_d) + (TxPtrW+1)'(txq_fill_d);
            if (wsum >= (TxPtrW+1)'(TxqSize)) begin
              wsum = wsum - (TxPtrW+1)'(TxqSize);
            end
            if (wsum[TxPtrW-1:0] == '0) begin
              slot0_we   = 1'b1;
              slot0_wval = data_byte;
            end else begin
              mem_we   = 1'b1;
              mem_widx = wsum[TxPtrW-1:0];
            end
            txq_fill_d = txq_fill_d + 1'b1;
            if (is_last) begin
              loading_d = 1'b0;
              mode_d    = ModeInit;
              if (mode_q == ModeRepStart) begin
                pop_en = 1'b1;
                act    = ActTx;
              end else begin
                act = ActStart;
              end
            end
          end
        end
      end
      ReqRead: begin
        if (!ready_now) begin
          status = StatBusy;
        end else if (read_count > CountW'(BufferDepth)) begin
          status = StatTooLarge;
        end else begin
          txq_head_d  = '0;
          txq_fill_d  = TxFillW'(1);
          loading_d   = 1'b0;
          slot0_we    = 1'b1;
          slot0_wval  = {slave_addr_q, RdBit};
          rd_target_d = read_count;
          rcv_cnt_d   = '0;
          mode_d      = ModeInit;
          if (mode_q == ModeRepStart) begin
            pop_en = 1'b1;
            act    = ActTx;
          end else begin
            act = ActStart;
          end
        end
      end
      ReqEvent: begin
        if (ev == EvRxAck || ev == EvRxNack) begin
          rxq_ctrl.push = 1'b1;
          if (rcv_cnt_q != RcvCntMax) begin
            rcv_cnt_d = rcv_cnt_q + 1'b1;
          end
        end
        cnt_next = (RcvCntW+1)'(rcv_cnt_d) + 1'b1;
        case (ev)
          EvStart, EvAddrWAck, EvTxAck: begin
            if (ev == EvAddrWAck) begin
              mode_d = ModeTx;
            end
            if (txq_fill_q != '0) begin
              pop_en = 1'b1;
              err_d  = ErrBusy;
              act    = ActTx;
            end else begin
              err_d = ErrNone;
              if (rep_start_q) begin
                act = ActStart;
              end else begin
                mode_d = ModeReady;
                act    = ActStop;
              end
            end
          end
          EvAddrRAck, EvRxAck: begin
            if (ev == EvAddrRAck) begin
              mode_d = ModeRx;
            end
            err_d = ErrBusy;
            act   = (cnt_next < (RcvCntW+1)'(rd_target_q)) ? ActAck : ActNack;
          end
          EvRxNack, EvAddrWNack, EvAddrRNack, EvTxNack, EvArbLost: begin
            case (ev)
              EvAddrWNack: err_d = ErrAddrWNack;
              EvAddrRNack: err_d = ErrAddrRNack;
              EvTxNack:    err_d = ErrDataNack;
              EvArbLost:   err_d = ErrArbLost;
              default:     err_d = ErrNone;
            endcase
            if (rep_start_q) begin
              act = ActStart;
            end else begin
              mode_d = ModeReady;
              act    = ActStop;
            end
          end
          EvRepStart: begin
            mode_d = ModeRepStart;
          end
          EvIllegal: begin
            err_d  = ErrIllegal;
            mode_d = ModeReady;
            act    = ActStop;
          end
          default: begin
          end
        endcase
      end
      default: begin
        rxq_ctrl.pop = 1'b1;
        rxv          = rxq_stat.valid;
        rxb          = rxq_stat.valid ? rxq_stat.rdata : 8'h00;
      end
    endcase

    // take the head byte, seeing bytes written by this same item
    if (pop_en && (txq_fill_d != '0)) begin
      if (txq_head_d == '0) begin
        pop_val = slot0_we ? slot0_wval : txq_slot0_q;
      end else if (mem_we && (mem_widx == txq_head_d)) begin
        pop_val = mem_wval;
      end else begin
        pop_val = txq_mem_q[TxMemIdxW'(txq_head_d - 1'b1)];
      end
      txq_head_d = (txq_head_d == TxPtrW'(TxqSize - 1)) ? '0 : txq_head_d + 1'b1;
      txq_fill_d = txq_fill_d - 1'b1;
    end
  end

  assign mem_wsel  = TxMemIdxW'(mem_widx - 1'b1);
  assign txb       = (act == ActTx) ? pop_val : 8'h00;
  assign ready_res = (mode_d == ModeReady) || (mode_d == ModeRepStart);

  assign rxq_req.push  = rxq_ctrl.push && acc;
  assign rxq_req.pop   = rxq_ctrl.pop && acc;
  assign rxq_req.wdata = rxq_ctrl.wdata;

  i2cms_rxq u_rxq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (rxq_req),
    .stat_o (rxq_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= '0;
      rep_start_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSlaveAddr: slave_addr_q <= cfg_wdata_i;
        CfgRepStart:  rep_start_q  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeReady;
      err_q       <= ErrNone;
      txq_head_q  <= '0;
      txq_fill_q  <= '0;
      loading_q   <= 1'b0;
      rd_target_q <= '0;
      rcv_cnt_q   <= '0;
    end else if (acc) begin
      mode_q      <= mode_d;
      err_q       <= err_d;
      txq_head_q  <= txq_head_d;
      txq_fill_q  <= txq_fill_d;
      loading_q   <= loading_d;
      rd_target_q <= rd_target_d;
      rcv_cnt_q   <= rcv_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && slot0_we) begin
      txq_slot0_q <= slot0_wval;
    end
    if (acc && mem_we) begin
      txq_mem_q[mem_wsel] <= mem_wval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_data_q <= {3'b000, ready_res, rxv, rxb, status, err_d, mode_d, txb, act};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
